[rtl/core/aidl_pkg.sv]
// Shared types and constants for the active ID list.
// No dependencies; imported by aidl_core, active_id_list_top and the testbench.
`default_nettype none

package aidl_pkg;

    localparam int ID_W          = 8;
    localparam int COUNT_W       = 4;
    localparam int DEPTH_DEFAULT = 8;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]    oldest_id;
        logic [COUNT_W-1:0] entry_count;
        logic               dropped_oldest;
        logic               changed;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/active_id_list_top.sv]
// Top level of the active ID list: stream ports and the result output register.
// Depends on aidl_pkg and aidl_core.
//
//  Port group   Dir   Fields (lowest bit first)
//  i_s_*        in    tuser: op; tdata: caller_id
//  o_m_*        out   tdata: changed, dropped_oldest, entry_count, oldest_id
//
// An item is searched for entry by entry from the oldest; a remove that finds its
// ID then moves each later entry one place forward, and the oldest entry is read
// for the result; the single list memory read port reads one entry per cycle.
// Reset clears the count and the head pointer; memory contents need no clearing.
// The next item is taken once a result has moved into the output register,
// so a stalled output holds up at most one further item.
`default_nettype none

module active_id_list_top #(
    parameter int LIST_DEPTH = aidl_pkg::DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] caller_id
    input  wire logic [0:0]  i_s_tuser,   // [0] op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [0] changed, [1] dropped_oldest,
                                          // [5:2] entry_count, [13:6] oldest_id
);
    import aidl_pkg::*;

    logic      res_valid;
    logic      res_ready;
    t_result   res;
    logic      r_m_valid;
    logic [15:0] r_m_data;

    aidl_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req_op    (t_op'(i_s_tuser[0])),
        .i_req_id    (i_s_tdata[ID_W-1:0]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_m_data <= {2'b0, res.oldest_id, res.entry_count,
                         res.dropped_oldest, res.changed};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

[rtl/core/aidl_core.sv]
// List engine: ID store in a circular memory, sequential search and gap closing.
// Depends on aidl_pkg.
`default_nettype none

module aidl_core #(
    parameter int LIST_DEPTH = aidl_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire aidl_pkg::t_op               i_req_op,
    input  wire logic [aidl_pkg::ID_W-1:0]   i_req_id,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output aidl_pkg::t_result                o_res
);
    import aidl_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_OLDEST,
        ST_RESULT
    } t_state;

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [ID_W-1:0] r_id, n_id;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_pend_idx, n_pend_idx;
    logic            r_changed, n_changed;
    logic            r_dropped, n_dropped;

    logic [ID_W-1:0] mem [LIST_DEPTH];
    logic [ID_W-1:0] r_rdata;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [ID_W-1:0] wr_data;
    logic            hit;
    logic [CW+3:0]   count_ext;

    // Maps a position in the list (0 = oldest) onto a memory address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(pos);
        if (s >= SW'(LIST_DEPTH)) begin
            s = s - SW'(LIST_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign hit = r_pend && (r_rdata == r_id);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_changed  = r_changed;
        n_dropped  = r_dropped;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_id;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_op      = i_req_op;
                    n_id      = i_req_id;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_changed = 1'b0;
                    n_dropped = 1'b0;
                    n_state   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // One read issued per cycle; the data returned is registered and then compared with the searched ID.
                if (hit) begin
                    n_pend = 1'b0;
                    if (r_op == OP_REMOVE) begin
                        n_changed = 1'b1;
                        n_idx     = r_pend_idx + CW'(1);
                        n_state   = ST_SHIFT;
                    end else begin
                        n_state = ST_OLDEST;
                    end
                end else if (r_idx < r_count) begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(r_head, r_idx);
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (r_op == OP_ADD) begin
                        n_changed = 1'b1;
                        wr_en     = 1'b1;
                        if (r_count < CW'(LIST_DEPTH)) begin
                            wr_addr = phys(r_head, r_count);
                            n_count = r_count + CW'(1);
                        end else begin
                            // Full: the oldest slot takes the new ID and the head moves on.
                            wr_addr   = r_head;
                            n_dropped = 1'b1;
                            if (r_head == AW'(LIST_DEPTH - 1)) begin
                                n_head = '0;
                            end else begin
                                n_head = r_head + AW'(1);
                            end
                        end
                    end
                    n_state = ST_OLDEST;
                end
            end
            ST_SHIFT: begin
                // Each entry behind the removed one moves one place towards the front.
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = phys(r_head, r_pend_idx - CW'(1));
                    wr_data = r_rdata;
                end
                if (r_idx < r_count) begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(r_head, r_idx);
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - CW'(1);
                    n_state = ST_OLDEST;
                end
            end
            ST_OLDEST: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_op       <= n_op;
        r_id       <= n_id;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_changed  <= n_changed;
        r_dropped  <= n_dropped;
    end

    assign count_ext   = {4'b0, r_count};
    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_RESULT);

    always_comb begin
        o_res.changed        = r_changed;
        o_res.dropped_oldest = r_dropped;
        o_res.entry_count    = count_ext[COUNT_W-1:0];
        o_res.oldest_id      = (r_count != '0) ? r_rdata : '0;
    end

endmodule

`default_nettype wire

[bench/tb_active_id_list_top.sv]
// Self-checking testbench for active_id_list_top: ordered ID list with oldest eviction.
// Depends on aidl_pkg and the RTL under rtl/core. Items are driven from a queue and
// each result is checked against a behavioural model of the list.
module tb_active_id_list_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aidl_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        t_op             op;
        logic [ID_W-1:0] caller_id;
        int unsigned     gap;
    } t_req;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] caller_id
    logic [0:0]  i_s_tuser  = '0;   // [0] op
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [0] changed, [1] dropped_oldest,
                                    // [5:2] entry_count, [13:6] oldest_id

    active_id_list_top #(
        .LIST_DEPTH (DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Model of the list contents, oldest entry at index 0.
    logic [ID_W-1:0] shadow_ids [DEPTH];
    int              shadow_count = 0;

    t_req    req_queue[$];
    t_result expected_results[$];
    int      total_items   = 0;
    int      n_accepted    = 0;
    int      n_results     = 0;
    int      mismatches    = 0;
    int      idle_cycles   = 0;
    bit      sender_calm   = 1'b0;

    int unsigned gap_left;
    t_req        cur_req;

    bit          sink_calm       = 1'b0;
    int unsigned sink_stall_left = 0;
    int unsigned sink_stretch    = 0;
    t_result     got;
    t_result     exp_res;

    function automatic t_result apply_list_update(t_op op, logic [ID_W-1:0] id);
        t_result r;
        int      pos;
        r   = '0;
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_ids[i] == id) pos = i;
        end
        if (op == OP_ADD) begin
            if (pos == shadow_count) begin
                r.changed = 1'b1;
                if (shadow_count < DEPTH) begin
                    shadow_ids[shadow_count] = id;
                    shadow_count++;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) shadow_ids[i] = shadow_ids[i + 1];
                    shadow_ids[DEPTH - 1] = id;
                    r.dropped_oldest      = 1'b1;
                end
            end
        end else if (pos < shadow_count) begin
            r.changed = 1'b1;
            shadow_count--;
            for (int i = pos; i < shadow_count; i++) shadow_ids[i] = shadow_ids[i + 1];
        end
        r.entry_count = COUNT_W'(shadow_count);
        r.oldest_id   = (shadow_count > 0) ? shadow_ids[0] : '0;
        return r;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_req(t_op op, logic [ID_W-1:0] id);
        t_req r;
        r.op        = op;
        r.caller_id = id;
        r.gap       = sender_calm ? 0 : pick_idle_len();
        req_queue.push_back(r);
    endtask

    // Sender: presents queued items, predicting each one as its beat is taken.
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            expected_results.push_back(apply_list_update(t_op'(i_s_tuser[0]), i_s_tdata));
            n_accepted++;
        end
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                cur_req = req_queue.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= cur_req.caller_id;
                i_s_tuser  <= 1'(cur_req.op);
                gap_left = cur_req.gap;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result, with random back-pressure in stretches, some of them free of stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[13:0]);
            n_results++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: tdata=%04h",
                             n_results, o_m_tdata);
            end else begin
                exp_res = expected_results.pop_front();
                if (got.changed !== exp_res.changed
                        || got.dropped_oldest !== exp_res.dropped_oldest
                        || got.entry_count !== exp_res.entry_count
                        || got.oldest_id !== exp_res.oldest_id) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch:", n_results);
                        $display("  expected changed=%0d dropped=%0d count=%0d oldest=%02h",
                                 exp_res.changed, exp_res.dropped_oldest,
                                 exp_res.entry_count, exp_res.oldest_id);
                        $display("  got      changed=%0d dropped=%0d count=%0d oldest=%02h",
                                 got.changed, got.dropped_oldest, got.entry_count,
                                 got.oldest_id);
                    end
                end
            end
        end
        if (sink_stretch == 0) begin
            sink_stretch = $urandom_range(50, 300);
            sink_calm    = ($urandom_range(0, 3) == 0);
        end else begin
            sink_stretch--;
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_stall_left > 0) begin
            sink_stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 5) == 0)
                sink_stall_left = pick_idle_len() + 1;
        end
    end

    // Counts cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        logic [ID_W-1:0] pool [16];
        int              pool_size;
        int              seg_len;
        int              add_pct;
        int              produced;

        // Directed part: empty list, field extremes, duplicates, eviction on a full
        // list, removal at the front, the back and the middle, and draining to empty.
        push_req(OP_REMOVE, 8'h55);
        push_req(OP_ADD, 8'h00);
        push_req(OP_ADD, 8'hFF);
        push_req(OP_ADD, 8'h00);
        push_req(OP_REMOVE, 8'hAA);
        push_req(OP_ADD, 8'h01);
        push_req(OP_ADD, 8'h02);
        push_req(OP_ADD, 8'h04);
        push_req(OP_ADD, 8'h08);
        push_req(OP_ADD, 8'h10);
        push_req(OP_ADD, 8'h20);
        push_req(OP_ADD, 8'h40);
        push_req(OP_ADD, 8'h80);
        push_req(OP_ADD, 8'h40);
        push_req(OP_REMOVE, 8'h80);
        push_req(OP_REMOVE, 8'h01);
        push_req(OP_REMOVE, 8'h08);
        push_req(OP_REMOVE, 8'hFF);
        push_req(OP_REMOVE, 8'h02);
        push_req(OP_REMOVE, 8'h04);
        push_req(OP_REMOVE, 8'h10);
        push_req(OP_REMOVE, 8'h20);
        push_req(OP_REMOVE, 8'h40);
        push_req(OP_REMOVE, 8'h40);

        // Random part in segments: a small pool of IDs gives plenty of hits, and the
        // add bias swings the list between empty and full.
        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            pool_size   = $urandom_range(3, 16);
            seg_len     = $urandom_range(40, 150);
            add_pct     = $urandom_range(25, 90);
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < pool_size; i++) pool[i] = ID_W'($urandom_range(0, 255));
            for (int i = 0; i < seg_len && produced < RANDOM_ITEMS; i++) begin
                push_req(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE,
                         ($urandom_range(0, 19) == 0) ? ID_W'($urandom_range(0, 255))
                                                      : pool[$urandom_range(0, pool_size - 1)]);
                produced++;
            end
        end
        total_items = req_queue.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_accepted == total_items && expected_results.size() == 0)
                && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        if (idle_cycles < IDLE_LIMIT) repeat (TAIL_CYCLES) @(posedge i_clk);

        if (idle_cycles < IDLE_LIMIT && mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
